>>> sv/pfd_pkg.sv
// ============================================================================
// pfd_pkg
// Shared constants, types and index helpers for the flux divergence core.
// ============================================================================
`default_nettype none

package pfd_pkg;

    localparam int GRID_X   = 16;
    localparam int GRID_Y   = 16;
    localparam int GRID_Z   = 16;
    localparam int CELLS    = GRID_X * GRID_Y * GRID_Z;
    localparam int ADDR_W   = $clog2(CELLS);

    localparam int COORD_W  = 4;
    localparam int DATA_W   = 16;
    localparam int FLUX_W   = 2 * DATA_W;
    localparam int DIFF_W   = FLUX_W + 1;
    localparam int RECIP_W  = 16;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = DIFF_W + RECIP_W + 1;
    localparam int OUT_W    = PROD_W - FRAC_W;
    localparam int DIMS_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int LANES    = 3;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DIMS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_TWO_DX = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_TWO_DY = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_TWO_DZ = CFG_IDX_W'(3);

    localparam logic [DIMS_W-1:0]  DIMS_RESET  = DIMS_W'(3);
    localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(32768);

    typedef logic signed [FLUX_W-1:0] t_flux;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [OUT_W-1:0]  t_term;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [COORD_W-1:0]       t_coord;

    function automatic t_addr cell_addr(input t_coord x, input t_coord y, input t_coord z);
        int idx;
        idx = (int'(x) * GRID_Y + int'(y)) * GRID_Z + int'(z);
        return ADDR_W'(idx);
    endfunction

    function automatic t_coord nb_up(input t_coord c, input int n);
        int v;
        v = (int'(c) >= n - 1) ? 0 : int'(c) + 1;
        return COORD_W'(v);
    endfunction

    function automatic t_coord nb_dn(input t_coord c, input int n);
        int v;
        v = (int'(c) == 0) ? n - 1 : int'(c) - 1;
        return COORD_W'(v);
    endfunction

    function automatic logic in_grid(input t_coord x, input t_coord y, input t_coord z);
        logic ok;
        ok = (int'(x) < GRID_X) && (int'(y) < GRID_Y) && (int'(z) < GRID_Z);
        return ok;
    endfunction

endpackage

`default_nettype wire

>>> sv/pfd_ram.sv
// ============================================================================
// pfd_ram
// Single-port synchronous RAM, one write or read per cycle, registered read.
// ============================================================================
`default_nettype none

module pfd_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [W-1:0]             i_wdata,
    output logic      [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

>>> sv/periodic_flux_divergence_core.sv
// ============================================================================
// periodic_flux_divergence_core
// Central-difference flux divergence on a periodic grid, flux held in memory.
// ============================================================================
// A load request stores density*velocity for each axis into three single-port
// flux memories; it produces no result. A query request reads the upper
// neighbours at acceptance and the lower neighbours in the next cycle through
// the same memory port; then the subtract, the multiply by the reciprocal
// spacing and the sum are registered in turn, and the sum waits until the
// output register is free. The next request is taken once the controller is
// idle again; a result waiting in the output register does not block it.
// Queries are only meaningful after every cell has been loaded.
`default_nettype none

module periodic_flux_divergence_core
    import pfd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_req_type,
    input  wire logic [COORD_W-1:0]    i_cell_x,
    input  wire logic [COORD_W-1:0]    i_cell_y,
    input  wire logic [COORD_W-1:0]    i_cell_z,
    input  wire logic signed [DATA_W-1:0] i_density,
    input  wire logic signed [DATA_W-1:0] i_vel_x,
    input  wire logic signed [DATA_W-1:0] i_vel_y,
    input  wire logic signed [DATA_W-1:0] i_vel_z,

    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [OUT_W-1:0]    o_div_value,

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [RECIP_W-1:0]    i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LO   = 3'd1;
    localparam logic [2:0] S_DIF  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [DIMS_W-1:0]  r_active_dims;
    logic [RECIP_W-1:0] r_recip [LANES];
    t_coord             r_x, r_y, r_z;
    logic               r_inside;
    t_flux              r_hi   [LANES];
    t_diff              r_diff [LANES];
    t_term              r_term [LANES];
    logic               r_out_valid;
    t_term              r_div_value;

    logic  w_in_acc, w_load, w_query, w_in_inside, w_we, w_out_free;
    logic  w_lane_en [LANES];
    t_addr w_addr    [LANES];
    t_flux w_wdata   [LANES];
    t_flux w_rdata   [LANES];
    t_flux w_den_ext;
    t_flux w_vel_ext [LANES];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_div_value = r_div_value;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_in_inside = in_grid(i_cell_x, i_cell_y, i_cell_z);
    assign w_load      = w_in_acc && (i_req_type == REQ_LOAD);
    assign w_query     = w_in_acc && (i_req_type == REQ_QUERY);
    assign w_we        = w_load && w_in_inside;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // zero active dims behaves as one
    assign w_lane_en[0] = r_inside;
    assign w_lane_en[1] = r_inside && (r_active_dims >= DIMS_W'(2));
    assign w_lane_en[2] = r_inside && (r_active_dims == DIMS_W'(3));

    assign w_den_ext    = {{DATA_W{i_density[DATA_W-1]}}, i_density};
    assign w_vel_ext[0] = {{DATA_W{i_vel_x[DATA_W-1]}}, i_vel_x};
    assign w_vel_ext[1] = {{DATA_W{i_vel_y[DATA_W-1]}}, i_vel_y};
    assign w_vel_ext[2] = {{DATA_W{i_vel_z[DATA_W-1]}}, i_vel_z};

    // address: load cell or upper neighbour while idle, lower neighbour after
    always_comb begin
        if (r_state == S_IDLE) begin
            if (i_req_type == REQ_LOAD) begin
                w_addr[0] = cell_addr(i_cell_x, i_cell_y, i_cell_z);
                w_addr[1] = cell_addr(i_cell_x, i_cell_y, i_cell_z);
                w_addr[2] = cell_addr(i_cell_x, i_cell_y, i_cell_z);
            end else begin
                w_addr[0] = cell_addr(nb_up(i_cell_x, GRID_X), i_cell_y, i_cell_z);
                w_addr[1] = cell_addr(i_cell_x, nb_up(i_cell_y, GRID_Y), i_cell_z);
                w_addr[2] = cell_addr(i_cell_x, i_cell_y, nb_up(i_cell_z, GRID_Z));
            end
        end else begin
            w_addr[0] = cell_addr(nb_dn(r_x, GRID_X), r_y, r_z);
            w_addr[1] = cell_addr(r_x, nb_dn(r_y, GRID_Y), r_z);
            w_addr[2] = cell_addr(r_x, r_y, nb_dn(r_z, GRID_Z));
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            t_prod w_prod;

            assign w_wdata[g] = w_den_ext * w_vel_ext[g];
            assign w_prod     = r_diff[g] * $signed({1'b0, r_recip[g]});

            pfd_ram #(
                .W     (FLUX_W),
                .DEPTH (CELLS)
            ) u_flux_ram (
                .i_clk   (i_clk),
                .i_we    (w_we),
                .i_addr  (w_addr[g]),
                .i_wdata (w_wdata[g]),
                .o_rdata (w_rdata[g])
            );

            always_ff @(posedge i_clk) begin
                if (r_state == S_LO) begin
                    r_hi[g] <= w_rdata[g];
                end
                if (r_state == S_DIF) begin
                    if (w_lane_en[g]) begin
                        r_diff[g] <= {r_hi[g][FLUX_W-1], r_hi[g]}
                                   - {w_rdata[g][FLUX_W-1], w_rdata[g]};
                    end else begin
                        r_diff[g] <= '0;
                    end
                end
                if (r_state == S_MUL) begin
                    r_term[g] <= w_prod[PROD_W-1:FRAC_W];
                end
            end
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_state = S_LO;
                end
            end
            S_LO:  n_state = S_DIF;
            S_DIF: n_state = S_MUL;
            S_MUL: n_state = S_SUM;
            S_SUM: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_active_dims <= DIMS_RESET;
            r_recip[0]    <= RECIP_RESET;
            r_recip[1]    <= RECIP_RESET;
            r_recip[2]    <= RECIP_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == S_SUM && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ACTIVE_DIMS:  r_active_dims <= i_cfg_data[DIMS_W-1:0];
                    REG_RECIP_TWO_DX: r_recip[0]    <= i_cfg_data;
                    REG_RECIP_TWO_DY: r_recip[1]    <= i_cfg_data;
                    REG_RECIP_TWO_DZ: r_recip[2]    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_x      <= i_cell_x;
            r_y      <= i_cell_y;
            r_z      <= i_cell_z;
            r_inside <= w_in_inside;
        end
        if (r_state == S_SUM && w_out_free) begin
            r_div_value <= r_term[0] + r_term[1] + r_term[2];
        end
    end

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE))
        else $error("flux memory written outside idle");

    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query |=> (r_state == S_LO))
        else $error("query request did not start the read sequence");

    a_lo_to_dif: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LO) |=> (r_state == S_DIF))
        else $error("lower neighbour read not followed by subtract");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented on completion");

endmodule

`default_nettype wire

>>> sim/flux_divergence_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// flux_divergence_checker
// Watches the request, result and register channels of the flux divergence
// core. It keeps its own flux stores and settings, predicts the divergence of
// every query request and compares each result with the oldest prediction.
// ============================================================================

module flux_divergence_checker
    import pfd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_req_type,
    input  logic [COORD_W-1:0]       i_cell_x,
    input  logic [COORD_W-1:0]       i_cell_y,
    input  logic [COORD_W-1:0]       i_cell_z,
    input  logic signed [DATA_W-1:0] i_density,
    input  logic signed [DATA_W-1:0] i_vel_x,
    input  logic signed [DATA_W-1:0] i_vel_y,
    input  logic signed [DATA_W-1:0] i_vel_z,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [OUT_W-1:0]  i_div_value,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [RECIP_W-1:0]       i_cfg_data,
    output int                       o_failures,
    output int                       o_pending
);

    t_flux                   flux_x [CELLS];
    t_flux                   flux_y [CELLS];
    t_flux                   flux_z [CELLS];
    logic [DIMS_W-1:0]       dims_sel;
    logic [RECIP_W-1:0]      recip_x;
    logic [RECIP_W-1:0]      recip_y;
    logic [RECIP_W-1:0]      recip_z;
    logic signed [OUT_W-1:0] div_expected [$];

    function automatic int slot(input t_coord x, input t_coord y, input t_coord z);
        return (int'(x) * GRID_Y + int'(y)) * GRID_Z + int'(z);
    endfunction

    function automatic t_coord wrap_up(input t_coord c, input int n);
        return t_coord'((int'(c) + 1) % n);
    endfunction

    function automatic t_coord wrap_dn(input t_coord c, input int n);
        return t_coord'((int'(c) + n - 1) % n);
    endfunction

    // (hi - lo) * recip, floored shift by the fraction width
    function automatic logic signed [OUT_W-1:0] axis_term(input t_flux hi, input t_flux lo,
                                                          input logic [RECIP_W-1:0] recip);
        logic signed [PROD_W-1:0] h;
        logic signed [PROD_W-1:0] l;
        logic signed [PROD_W-1:0] r;
        logic signed [PROD_W-1:0] prod;
        h = hi;
        l = lo;
        r = $signed({1'b0, recip});
        prod = (h - l) * r;
        return OUT_W'(prod >>> FRAC_W);
    endfunction

    function automatic logic signed [OUT_W-1:0] predict_divergence(input t_coord x,
                                                                   input t_coord y,
                                                                   input t_coord z);
        logic signed [OUT_W-1:0] sum;
        logic [DIMS_W-1:0]       dims;
        sum = '0;
        // no active dimension still sums the x term
        dims = (dims_sel == '0) ? DIMS_W'(1) : dims_sel;
        if (int'(x) < GRID_X && int'(y) < GRID_Y && int'(z) < GRID_Z) begin
            sum = axis_term(flux_x[slot(wrap_up(x, GRID_X), y, z)],
                            flux_x[slot(wrap_dn(x, GRID_X), y, z)], recip_x);
            if (dims >= 2) begin
                sum += axis_term(flux_y[slot(x, wrap_up(y, GRID_Y), z)],
                                 flux_y[slot(x, wrap_dn(y, GRID_Y), z)], recip_y);
            end
            if (dims >= 3) begin
                sum += axis_term(flux_z[slot(x, y, wrap_up(z, GRID_Z))],
                                 flux_z[slot(x, y, wrap_dn(z, GRID_Z))], recip_z);
            end
        end
        return sum;
    endfunction

    always @(posedge i_clk) begin : watch
        logic signed [OUT_W-1:0] want;
        int                      k;
        if (!i_rst_n) begin
            dims_sel   <= DIMS_RESET;
            recip_x    <= RECIP_RESET;
            recip_y    <= RECIP_RESET;
            recip_z    <= RECIP_RESET;
            o_failures <= 0;
            o_pending  <= 0;
            div_expected.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (div_expected.size() == 0) begin
                    $error("div_value: unexpected result, expected none, actual %0d",
                           i_div_value);
                    o_failures <= o_failures + 1;
                end else begin
                    want = div_expected.pop_front();
                    if (i_div_value !== want) begin
                        $error("div_value: expected %0d, actual %0d", want, i_div_value);
                        o_failures <= o_failures + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_req_type == REQ_LOAD) begin
                    // loads outside the grid are dropped
                    if (int'(i_cell_x) < GRID_X && int'(i_cell_y) < GRID_Y &&
                        int'(i_cell_z) < GRID_Z) begin
                        k = slot(i_cell_x, i_cell_y, i_cell_z);
                        flux_x[k] = i_density * i_vel_x;
                        flux_y[k] = i_density * i_vel_y;
                        flux_z[k] = i_density * i_vel_z;
                    end
                end else begin
                    div_expected.push_back(predict_divergence(i_cell_x, i_cell_y, i_cell_z));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ACTIVE_DIMS:  dims_sel <= i_cfg_data[DIMS_W-1:0];
                    REG_RECIP_TWO_DX: recip_x  <= i_cfg_data;
                    REG_RECIP_TWO_DY: recip_y  <= i_cfg_data;
                    REG_RECIP_TWO_DZ: recip_z  <= i_cfg_data;
                    default: ;
                endcase
            end
            o_pending <= div_expected.size();
        end
    end

endmodule

>>> sim/periodic_flux_divergence_core_test.sv
`timescale 1ns / 100ps
// ============================================================================
// periodic_flux_divergence_core_test
// Drives load and query requests and register writes into the flux divergence
// core: a directed pass over grid corners and extreme values, then random
// phases under several settings, with random idling on both channels. A
// checker beside the core predicts and compares every result.
// ============================================================================

module periodic_flux_divergence_core_test;
    import pfd_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 12;
    localparam int N_PHASES      = 5;
    localparam int PHASE_ITEMS   = 385;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int FIRST_SPARE_REG = int'(REG_RECIP_TWO_DZ) + 1;
    localparam int LAST_REG        = (1 << CFG_IDX_W) - 1;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     req_type = REQ_LOAD;
    logic [COORD_W-1:0]       cell_x = '0;
    logic [COORD_W-1:0]       cell_y = '0;
    logic [COORD_W-1:0]       cell_z = '0;
    logic signed [DATA_W-1:0] density = '0;
    logic signed [DATA_W-1:0] vel_x = '0;
    logic signed [DATA_W-1:0] vel_y = '0;
    logic signed [DATA_W-1:0] vel_z = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [OUT_W-1:0]  div_value;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [RECIP_W-1:0]       cfg_data = '0;

    int   failures;
    int   pending;
    int   sent = 0;
    logic steady = 1'b0;
    bit   loaded [CELLS];

    always #HALF_PERIOD clk = ~clk;

    periodic_flux_divergence_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_req_type  (req_type),
        .i_cell_x    (cell_x),
        .i_cell_y    (cell_y),
        .i_cell_z    (cell_z),
        .i_density   (density),
        .i_vel_x     (vel_x),
        .i_vel_y     (vel_y),
        .i_vel_z     (vel_z),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_div_value (div_value),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    flux_divergence_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_req_type  (req_type),
        .i_cell_x    (cell_x),
        .i_cell_y    (cell_y),
        .i_cell_z    (cell_z),
        .i_density   (density),
        .i_vel_x     (vel_x),
        .i_vel_y     (vel_y),
        .i_vel_z     (vel_z),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_div_value (div_value),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= 15);
    end

    // mostly random, with the extremes now and then
    function automatic logic [DATA_W-1:0] pick_sample();
        case ($urandom_range(19))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic send(input logic kind, input t_coord x, input t_coord y, input t_coord z,
                        input logic [DATA_W-1:0] den, input logic [DATA_W-1:0] vx,
                        input logic [DATA_W-1:0] vy, input logic [DATA_W-1:0] vz);
        in_valid <= 1'b1;
        req_type <= kind;
        cell_x   <= x;
        cell_y   <= y;
        cell_z   <= z;
        density  <= den;
        vel_x    <= vx;
        vel_y    <= vy;
        vel_z    <= vz;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (kind == REQ_LOAD) begin
            loaded[cell_addr(x, y, z)] = 1'b1;
        end
        sent++;
        if (!steady && $urandom_range(99) < 15) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // query payload fields are don't-care, so fill them with noise
    task automatic query(input t_coord x, input t_coord y, input t_coord z);
        send(REQ_QUERY, x, y, z, DATA_W'($urandom), DATA_W'($urandom),
             DATA_W'($urandom), DATA_W'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RECIP_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [DIMS_W-1:0] dims, input logic [RECIP_W-1:0] dx,
                                 input logic [RECIP_W-1:0] dy, input logic [RECIP_W-1:0] dz);
        logic [RECIP_W-1:0] dims_word;
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        dims_word = RECIP_W'($urandom);
        dims_word[DIMS_W-1:0] = dims;
        write_reg(REG_ACTIVE_DIMS, dims_word);
        write_reg(REG_RECIP_TWO_DX, dx);
        write_reg(REG_RECIP_TWO_DY, dy);
        write_reg(REG_RECIP_TWO_DZ, dz);
        // unmapped index, must be ignored
        write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, LAST_REG)), RECIP_W'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic touch_neighbour(input t_coord x, input t_coord y, input t_coord z);
        if (!loaded[cell_addr(x, y, z)] || $urandom_range(3) == 0) begin
            send(REQ_LOAD, x, y, z, pick_sample(), pick_sample(), pick_sample(), pick_sample());
        end
    endtask

    // make sure all six neighbours hold data, then query the centre
    task automatic query_sequence();
        t_coord x;
        t_coord y;
        t_coord z;
        x = t_coord'($urandom);
        y = t_coord'($urandom);
        z = t_coord'($urandom);
        touch_neighbour(nb_up(x, GRID_X), y, z);
        touch_neighbour(nb_dn(x, GRID_X), y, z);
        touch_neighbour(x, nb_up(y, GRID_Y), z);
        touch_neighbour(x, nb_dn(y, GRID_Y), z);
        touch_neighbour(x, y, nb_up(z, GRID_Z));
        touch_neighbour(x, y, nb_dn(z, GRID_Z));
        query(x, y, z);
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int  base;
        bit  paused;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // wrap-around at the low corner, largest positive difference on x
        send(REQ_LOAD, 4'd1,  4'd0,  4'd0,  16'h8000, 16'h8000, pick_sample(), pick_sample());
        send(REQ_LOAD, 4'd15, 4'd0,  4'd0,  16'h8000, 16'h7fff, pick_sample(), pick_sample());
        send(REQ_LOAD, 4'd0,  4'd1,  4'd0,  16'h7fff, pick_sample(), 16'h7fff, pick_sample());
        send(REQ_LOAD, 4'd0,  4'd15, 4'd0,  16'h8000, pick_sample(), 16'h7fff, pick_sample());
        send(REQ_LOAD, 4'd0,  4'd0,  4'd1,  16'h0000, pick_sample(), pick_sample(), 16'h7fff);
        send(REQ_LOAD, 4'd0,  4'd0,  4'd15, 16'hffff, pick_sample(), pick_sample(), 16'h0001);
        query(4'd0, 4'd0, 4'd0);
        // wrap-around at the high corner, largest negative difference on x
        send(REQ_LOAD, 4'd0,  4'd15, 4'd15, 16'h8000, 16'h7fff, pick_sample(), pick_sample());
        send(REQ_LOAD, 4'd14, 4'd15, 4'd15, 16'h8000, 16'h8000, pick_sample(), pick_sample());
        send(REQ_LOAD, 4'd15, 4'd0,  4'd15, 16'h8000, pick_sample(), 16'h8000, pick_sample());
        send(REQ_LOAD, 4'd15, 4'd14, 4'd15, 16'h7fff, pick_sample(), 16'h8000, pick_sample());
        send(REQ_LOAD, 4'd15, 4'd15, 4'd0,  16'h7fff, pick_sample(), pick_sample(), 16'h7fff);
        send(REQ_LOAD, 4'd15, 4'd15, 4'd14, 16'h8000, pick_sample(), pick_sample(), 16'h8000);
        query(4'd15, 4'd15, 4'd15);
        // zero active dimensions falls back to x only
        apply_setting(2'd0, 16'hffff, 16'h0000, 16'h0000);
        query(4'd0, 4'd0, 4'd0);
        query(4'd15, 4'd15, 4'd15);
        apply_setting(2'd2, 16'h0000, 16'hffff, 16'h0001);
        query(4'd0, 4'd0, 4'd0);
        query(4'd15, 4'd15, 4'd15);

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       apply_setting(2'd3, 16'hffff, 16'hffff, 16'hffff);
                1:       apply_setting(2'd0, 16'h0001, 16'h0000, 16'hffff);
                2:       apply_setting(2'd1, RECIP_W'($urandom), RECIP_W'($urandom),
                                       RECIP_W'($urandom));
                3:       apply_setting(2'd2, 16'h0000, 16'hffff, RECIP_W'($urandom));
                default: apply_setting(2'd3, RECIP_W'($urandom), RECIP_W'($urandom),
                                       RECIP_W'($urandom));
            endcase
            steady <= (p == 2);
            @(posedge clk);
            base = sent;
            paused = 1'b0;
            while (sent - base < PHASE_ITEMS) begin
                if (!paused && sent - base >= PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 75) begin
                    query_sequence();
                end else begin
                    send(REQ_LOAD, t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                         pick_sample(), pick_sample(), pick_sample(), pick_sample());
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
